### rtl/plti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int IDX_W       = 6;
    localparam int SEG_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int NPTS_W      = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_POINTS    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOUNDARY_MODE = 1'b1;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INTERP    = 2'd0,
        STAT_HOLD_LOW  = 2'd1,
        STAT_HOLD_HIGH = 2'd2,
        STAT_TOO_SMALL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_SCAN,
        ST_SEG,
        ST_MUL,
        ST_DIV0,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CAP_LO,
        OP_CHECK,
        OP_SCAN,
        OP_SEG,
        OP_MUL_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIN,
        OP_LOAD_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic n_small;
        logic hold_lo;
        logic hold_hi;
        logic scan_stop;
        logic x_equal;
    } stat_t;

endpackage
`default_nettype wire

### rtl/plti_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/plti_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer for table search, serial multiply, serial divide and output.
// ----------------------------------------------------------------------------
module plti_ctrl #(
    parameter int VALUE_BITS = plti_pkg::VALUE_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic            s_mode,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire plti_pkg::stat_t stat,
    output plti_pkg::cmd_t       cmd
);
    import plti_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               cnt_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign cnt_last = (cnt_reg == CNT_W'(VALUE_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op = OP_ACCEPT;
                    if (s_mode == MODE_QUERY) begin
                        state_next = stat.n_small ? ST_DONE : ST_LO;
                    end
                end
            end
            ST_LO: begin
                cmd.op     = OP_CAP_LO;
                state_next = ST_HI;
            end
            ST_HI: begin
                cmd.op     = OP_CHECK;
                state_next = (stat.hold_lo || stat.hold_hi) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.op = OP_SCAN;
                if (stat.scan_stop) begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                cmd.op     = OP_SEG;
                cnt_next   = '0;
                state_next = stat.x_equal ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_DIV0;
                end
            end
            ST_DIV0: begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.op     = OP_FIN;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.op         = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_mul_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) && cnt_last |=> (state_reg == ST_DIV0))
        else $error("multiply did not hand over to divide");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && (!out_valid_reg || m_tready)
        |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result not presented");

    a_small_table: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_mode == MODE_QUERY) && stat.n_small |=> (state_reg == ST_DONE))
        else $error("small-table query did not go straight to output");
`endif

endmodule
`default_nettype wire

### rtl/plti_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plti_dp
// Datapath: breakpoint tables, config registers, search, multiply, divide.
// ----------------------------------------------------------------------------
module plti_dp #(
    parameter int MAX_POINTS = plti_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = plti_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire plti_pkg::cmd_t                  cmd,
    output plti_pkg::stat_t                      stat,
    input  wire logic                            s_mode,
    input  wire logic [plti_pkg::IDX_W-1:0]      s_point_index,
    input  wire logic [VALUE_BITS-1:0]           s_x_value,
    input  wire logic [VALUE_BITS-1:0]           s_y_value,
    input  wire logic                            cfg_wr_en,
    input  wire logic [plti_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [plti_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output logic      [VALUE_BITS-1:0]           out_y,
    output logic      [plti_pkg::SEG_W-1:0]      out_seg,
    output logic      [plti_pkg::STATUS_W-1:0]   out_status
);
    import plti_pkg::*;

    localparam int W   = VALUE_BITS;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = (NW > NPTS_W) ? NW : NPTS_W;
    localparam int PW  = 2 * W + 2;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // configuration
    logic [NPTS_W-1:0] num_points_reg;
    logic              boundary_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg    <= '0;
            boundary_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_POINTS:    num_points_reg    <= cfg_wr_data;
                CFG_BOUNDARY_MODE: boundary_mode_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] n_ext, n_eff;
    logic [AW-1:0] n_last, n_pen;

    assign n_ext  = CW'(num_points_reg);
    assign n_eff  = (n_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : n_ext;
    assign n_last = AW'(n_eff - CW'(1));
    assign n_pen  = AW'(n_eff - CW'(2));

    // breakpoint tables
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [W-1:0]  rd_x_raw, rd_y_raw;
    logic signed [W-1:0] rd_x, rd_y;

    assign wr_en = (cmd.op == OP_ACCEPT) && (s_mode == MODE_WRITE)
                   && (32'(s_point_index) < 32'(MAX_POINTS));

    plti_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram_x (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_point_index)),
        .wr_data (s_x_value),
        .rd_addr (rd_addr),
        .rd_data (rd_x_raw)
    );

    plti_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_ram_y (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_point_index)),
        .wr_data (s_y_value),
        .rd_addr (rd_addr),
        .rd_data (rd_y_raw)
    );

    assign rd_x = $signed(rd_x_raw);
    assign rd_y = $signed(rd_y_raw);

    // working registers
    logic signed [W-1:0] qx_reg, x0_reg, y0_reg;
    logic [AW-1:0]       sidx_reg, seg_reg;
    logic [W:0]          a_reg, b_reg, d_reg;
    logic                neg_reg, ovf_reg;
    logic [PW-1:0]       acc_reg;
    logic [W:0]          rem_reg, low_reg, q_reg;
    logic [W-1:0]        res_y_reg;
    logic [AW-1:0]       res_seg_reg;
    status_t             res_stat_reg;

    // combinational helpers
    logic signed [W:0]   dx, dy, dxs;
    logic [W+1:0]        div_t;
    logic                div_ge;
    logic signed [W+2:0] y0e, qe, sum;
    logic                sum_fits;
    logic [W-1:0]        fin_y;

    assign stat.n_small   = (n_eff < CW'(2));
    assign stat.hold_lo   = !boundary_mode_reg && (qx_reg < x0_reg);
    assign stat.hold_hi   = !boundary_mode_reg && (qx_reg > rd_x);
    assign stat.scan_stop = (rd_x <= qx_reg) || (sidx_reg == '0);
    assign stat.x_equal   = (x0_reg == rd_x);

    assign dx  = (W+1)'(qx_reg) - (W+1)'(x0_reg);
    assign dy  = (W+1)'(rd_y) - (W+1)'(y0_reg);
    assign dxs = (W+1)'(rd_x) - (W+1)'(x0_reg);

    assign div_t  = {rem_reg, low_reg[W]};
    assign div_ge = (div_t >= {1'b0, d_reg});

    assign y0e      = (W+3)'(y0_reg);
    assign qe       = $signed({2'b00, q_reg});
    assign sum      = neg_reg ? (y0e - qe) : (y0e + qe);
    assign sum_fits = (&sum[W+2:W-1]) || !(|sum[W+2:W-1]);
    assign fin_y    = ovf_reg ? (neg_reg ? MINV : MAXV)
                    : (sum_fits ? sum[W-1:0] : (sum[W+2] ? MINV : MAXV));

    always_comb begin
        rd_addr = '0;
        unique case (cmd.op)
            OP_ACCEPT: rd_addr = '0;
            OP_CAP_LO: rd_addr = n_last;
            OP_CHECK:  rd_addr = n_pen;
            OP_SCAN:   rd_addr = stat.scan_stop ? (sidx_reg + 1'b1) : (sidx_reg - 1'b1);
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_ACCEPT: begin
                qx_reg       <= $signed(s_x_value);
                res_y_reg    <= '0;
                res_seg_reg  <= '0;
                res_stat_reg <= STAT_TOO_SMALL;
            end
            OP_CAP_LO: begin
                x0_reg <= rd_x;
                y0_reg <= rd_y;
            end
            OP_CHECK: begin
                sidx_reg <= n_pen;
                if (stat.hold_lo) begin
                    res_y_reg    <= y0_reg;
                    res_seg_reg  <= '0;
                    res_stat_reg <= STAT_HOLD_LOW;
                end else begin
                    res_y_reg    <= rd_y;
                    res_seg_reg  <= n_pen;
                    res_stat_reg <= STAT_HOLD_HIGH;
                end
            end
            OP_SCAN: begin
                if (stat.scan_stop) begin
                    seg_reg <= sidx_reg;
                    x0_reg  <= rd_x;
                    y0_reg  <= rd_y;
                end else begin
                    sidx_reg <= sidx_reg - 1'b1;
                end
            end
            OP_SEG: begin
                a_reg        <= dx[W]  ? (W+1)'(0) - dx  : dx;
                b_reg        <= dy[W]  ? (W+1)'(0) - dy  : dy;
                d_reg        <= dxs[W] ? (W+1)'(0) - dxs : dxs;
                neg_reg      <= dx[W] ^ dy[W] ^ dxs[W];
                acc_reg      <= '0;
                res_y_reg    <= y0_reg;
                res_seg_reg  <= seg_reg;
                res_stat_reg <= STAT_INTERP;
            end
            OP_MUL_STEP: begin
                // shift-add, multiplier MSB first
                acc_reg <= (acc_reg << 1) + (b_reg[W] ? PW'(a_reg) : PW'(0));
                b_reg   <= b_reg << 1;
            end
            OP_DIV_INIT: begin
                ovf_reg <= (acc_reg[PW-1:W+1] >= d_reg);
                rem_reg <= acc_reg[PW-1:W+1];
                low_reg <= acc_reg[W:0];
                q_reg   <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? (W+1)'(div_t - {1'b0, d_reg}) : div_t[W:0];
                low_reg <= low_reg << 1;
                q_reg   <= {q_reg[W-1:0], div_ge};
            end
            OP_FIN: begin
                res_y_reg    <= fin_y;
                res_seg_reg  <= seg_reg;
                res_stat_reg <= STAT_INTERP;
            end
            OP_LOAD_OUT: begin
                out_y      <= res_y_reg;
                out_seg    <= SEG_W'(res_seg_reg);
                out_status <= res_stat_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/piecewise_linear_table_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Loadable breakpoint table with linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// An item with tuser mode 0 writes one breakpoint (x, y) at point_index;
// writes at or beyond MAX_POINTS are dropped. An item with mode 1 queries
// x and returns one result item. A table under two points, a held end
// value or a segment whose two x values are equal skip the multiply and
// divide; a table under two points and a held end value also skip the
// segment scan. The scan walks the table downward from entry n-2, one RAM
// read per cycle, and reads 1 to n-1 entries; the multiply is a shift-add
// unit and the divide a restoring divider, each retiring one bit per cycle.
// One item is worked on at a time; the result sits in an output register,
// so the next item is accepted while the previous result still waits to be
// taken. Configuration (num_points, boundary_mode) is written through cfg_*;
// the user must write it only while the block is idle; the block itself
// does not enforce this. Breakpoint tables have no reset; query only entries
// that were written.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator #(
    parameter int MAX_POINTS = plti_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = plti_pkg::VALUE_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // input channel
    input  wire logic s_tvalid,
    output logic      s_tready,
    // tdata, low bit up: point_index[5:0], x_value, y_value, zero pad
    input  wire logic [((plti_pkg::IDX_W + 2*VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: mode
    input  wire logic s_tuser,
    // result channel
    output logic      m_tvalid,
    input  wire logic m_tready,
    // tdata, low bit up: y_result, segment[5:0], zero pad
    output logic [((VALUE_BITS + plti_pkg::SEG_W + 7) / 8) * 8 - 1:0] m_tdata,
    // tuser: status
    output logic [plti_pkg::STATUS_W-1:0] m_tuser,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [plti_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [plti_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import plti_pkg::*;

    localparam int W   = VALUE_BITS;
    localparam int MDW = ((W + SEG_W + 7) / 8) * 8;

    cmd_t             cmd;
    stat_t            stat;
    logic [W-1:0]     out_y;
    logic [SEG_W-1:0] out_seg;

    plti_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plti_dp #(.MAX_POINTS(MAX_POINTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_mode        (s_tuser),
        .s_point_index (s_tdata[IDX_W-1:0]),
        .s_x_value     (s_tdata[IDX_W+W-1:IDX_W]),
        .s_y_value     (s_tdata[IDX_W+2*W-1:IDX_W+W]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .out_y         (out_y),
        .out_seg       (out_seg),
        .out_status    (m_tuser)
    );

    // pack the result fields, pad to whole bytes
    assign m_tdata = MDW'({out_seg, out_y});

endmodule
`default_nettype wire
